@@ rtl/rwl_pkg.sv @@
package rwl_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned TOTAL_W = 8;

    typedef enum logic [1:0] {
        OP_START_READ  = 2'd0,
        OP_START_WRITE = 2'd1,
        OP_STOP_READ   = 2'd2,
        OP_STOP_WRITE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BUSY       = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_FULL       = 3'd3,
        ST_NO_READERS = 3'd4
    } t_status;

    typedef struct packed {
        t_op              opcode;
        logic [KEY_W-1:0] file_key;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [TOTAL_W-1:0] reader_total;
        logic               write_held;
    } t_rsp;

endpackage

@@ rtl/rwl_entry_ram.sv @@
module rwl_entry_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 41
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/reader_writer_lock_table.sv @@
// Channel   Direction  Handshake                  Word
// request   in         i_req_valid / o_req_stall  i_req (opcode, file_key)
// response  out        o_rsp_valid / i_rsp_stall  o_rsp (status, reader_total, write_held)
//
// A request passes from acceptance through S_SCAN, S_LAST and S_UPDATE to a loaded response,
// and S_SCAN reads one table entry per cycle through the single read port of the entry RAM.
// The request side stalls from acceptance until the response is loaded into the output register.
// The next request is accepted only once the previous one has left S_UPDATE.
// A new request is accepted while an earlier response still waits in the output register.
// Reset clears all entry valid bits at once; the entry RAM itself needs no clearing.
module reader_writer_lock_table #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned KEY_BITS      = 32,
    parameter int unsigned READER_BITS   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  rwl_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output rwl_pkg::t_rsp o_rsp
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned ENT_W = KEY_BITS + READER_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [READER_BITS-1:0] READER_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]         r_rd_idx, n_rd_idx;
    rwl_pkg::t_op             r_op, n_op;
    logic [KEY_BITS-1:0]      r_key, n_key;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_slot, n_slot;
    logic [READER_BITS-1:0]   r_ent_readers, n_ent_readers;
    logic                     r_ent_locked, n_ent_locked;
    logic                     r_have_free, n_have_free;
    logic [IDX_W-1:0]         r_free_idx, n_free_idx;
    logic                     r_rsp_valid, n_rsp_valid;
    rwl_pkg::t_rsp            r_rsp, n_rsp;

    logic                     req_acc;
    logic                     out_free;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENT_W-1:0]         ram_wdata;
    logic [ENT_W-1:0]         ram_rdata;
    logic [KEY_BITS-1:0]      rd_key;
    logic [READER_BITS-1:0]   rd_readers;
    logic                     rd_locked;
    logic                     key_hit;

    logic [IDX_W-1:0]         upd_slot;
    logic [READER_BITS-1:0]   cur_readers;
    logic                     cur_locked;
    logic [READER_BITS-1:0]   new_readers;
    logic                     new_locked;
    logic                     upd_keep;
    logic                     upd_free;
    rwl_pkg::t_status         upd_status;

    rwl_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENT_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_req_stall = (r_state != S_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign {rd_key, rd_readers, rd_locked} = ram_rdata;
    assign key_hit = r_valid[r_rd_idx] && (rd_key == r_key);

    always_comb begin
        upd_slot    = r_found ? r_slot : r_free_idx;
        cur_readers = r_found ? r_ent_readers : '0;
        cur_locked  = r_found && r_ent_locked;
        new_readers = cur_readers;
        new_locked  = cur_locked;
        upd_keep    = 1'b0;
        upd_free    = 1'b0;
        upd_status  = rwl_pkg::ST_OK;
        unique case (r_op)
            rwl_pkg::OP_START_READ, rwl_pkg::OP_START_WRITE: begin
                if (!r_found && !r_have_free) begin
                    upd_status = rwl_pkg::ST_FULL;
                end else begin
                    upd_keep = 1'b1;
                    if (r_op == rwl_pkg::OP_START_READ) begin
                        if (cur_readers == '0) begin
                            if (cur_locked) begin
                                upd_status = rwl_pkg::ST_BUSY;
                            end else begin
                                new_locked  = 1'b1;
                                new_readers = READER_BITS'(1);
                            end
                        end else if (cur_readers == READER_MAX) begin
                            upd_status = rwl_pkg::ST_BUSY;
                        end else begin
                            new_readers = cur_readers + READER_BITS'(1);
                        end
                    end else begin
                        if ((cur_readers != '0) || cur_locked) begin
                            upd_status = rwl_pkg::ST_BUSY;
                        end else begin
                            new_locked = 1'b1;
                        end
                    end
                end
            end
            rwl_pkg::OP_STOP_READ: begin
                if (!r_found) begin
                    upd_status = rwl_pkg::ST_NOT_FOUND;
                end else if (cur_readers == '0) begin
                    upd_status = rwl_pkg::ST_NO_READERS;
                end else begin
                    new_readers = cur_readers - READER_BITS'(1);
                    if (new_readers == '0) begin
                        upd_free = 1'b1;
                    end else begin
                        upd_keep = 1'b1;
                    end
                end
            end
            rwl_pkg::OP_STOP_WRITE: begin
                if (!r_found) begin
                    upd_status = rwl_pkg::ST_NOT_FOUND;
                end else begin
                    upd_free = 1'b1;
                end
            end
            default: begin
                upd_status = rwl_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_idx         = r_idx;
        n_rd_pend     = 1'b0;
        n_rd_idx      = r_idx;
        n_op          = r_op;
        n_key         = r_key;
        n_found       = r_found;
        n_slot        = r_slot;
        n_ent_readers = r_ent_readers;
        n_ent_locked  = r_ent_locked;
        n_have_free   = r_have_free;
        n_free_idx    = r_free_idx;
        n_rsp_valid   = r_rsp_valid && i_rsp_stall;
        n_rsp         = r_rsp;
        ram_we        = 1'b0;
        ram_waddr     = upd_slot;
        ram_wdata     = {r_key, new_readers, new_locked};

        if (r_rd_pend) begin
            if (key_hit && !r_found) begin
                n_found       = 1'b1;
                n_slot        = r_rd_idx;
                n_ent_readers = rd_readers;
                n_ent_locked  = rd_locked;
            end
            if (!r_valid[r_rd_idx] && !r_have_free) begin
                n_have_free = 1'b1;
                n_free_idx  = r_rd_idx;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_op        = i_req.opcode;
                    n_key       = KEY_BITS'(i_req.file_key);
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_idx       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                n_rd_pend = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_LAST: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    ram_we = upd_keep;
                    if (upd_keep) begin
                        n_valid[upd_slot] = 1'b1;
                    end
                    if (upd_free) begin
                        n_valid[upd_slot] = 1'b0;
                    end
                    n_rsp_valid   = 1'b1;
                    n_rsp.status  = upd_status;
                    if (upd_keep) begin
                        n_rsp.reader_total = rwl_pkg::TOTAL_W'(new_readers);
                        n_rsp.write_held   = new_locked && (new_readers == '0);
                    end else if (upd_status == rwl_pkg::ST_NO_READERS) begin
                        n_rsp.reader_total = '0;
                        n_rsp.write_held   = cur_locked;
                    end else begin
                        n_rsp.reader_total = '0;
                        n_rsp.write_held   = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rd_pend   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rd_pend   <= n_rd_pend;
            r_rsp_valid <= n_rsp_valid;
        end
        r_idx         <= n_idx;
        r_rd_idx      <= n_rd_idx;
        r_op          <= n_op;
        r_key         <= n_key;
        r_found       <= n_found;
        r_slot        <= n_slot;
        r_ent_readers <= n_ent_readers;
        r_ent_locked  <= n_ent_locked;
        r_have_free   <= n_have_free;
        r_free_idx    <= n_free_idx;
        r_rsp         <= n_rsp;
    end

    a_scan_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("accepted request did not start the scan at entry zero");

    a_read_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> $past(r_state == S_SCAN))
        else $error("entry compare without a scan read the cycle before");

    a_rsp_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == S_UPDATE))
        else $error("response loaded outside the update step");

    a_found_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPDATE) && r_found) |-> r_valid[r_slot])
        else $error("matched slot is not marked valid at update");

endmodule
